@@ src/rca_pkg.sv @@
// rca_pkg: shared types, character codes and the digit lookup for the radix
// conversion block. Depends on nothing; every other source file uses it.

package rca_pkg;

	// input beat: unsigned fixed-point value
	typedef struct packed {
		logic [31:0] int_part;
		logic [31:0] frac_part;
	} rca_in_t;

	// output beat: one character of the converted number
	typedef struct packed {
		logic [6:0] ascii_char;
		logic       last;
	} rca_out_t;

	// per-job control handed from the front end to the conversion engine
	typedef struct packed {
		logic [4:0] radix;
		logic       int_zero;
	} rca_job_ctl_t;

	localparam logic [4:0] RADIX_RESET = 5'd10;
	localparam logic [4:0] RADIX_MIN   = 5'd2;
	localparam logic [4:0] RADIX_MAX   = 5'd16;

	localparam logic [6:0] DOT_CHAR    = 7'h2E;
	localparam logic [6:0] ZERO_CHAR   = 7'h30;
	localparam logic [6:0] ALPHA_CHAR  = 7'h41;

	// digit value to ascii, uppercase letters above nine
	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = ZERO_CHAR + 7'(d);
		end else begin
			c = ALPHA_CHAR + 7'(d - 4'd10);
		end
		return c;
	endfunction

endpackage

@@ src/rca_front.sv @@
// rca_front: input side of the radix converter. Masks the fields, saturates
// the radix, flags a zero integer part and holds jobs in a two-entry queue.
// Depends on rca_pkg.

module rca_front #(
	parameter int INT_BITS  = 32,
	parameter int FRAC_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [4:0]                 radix,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  rca_pkg::rca_in_t           item_data,
	output logic                       job_valid,
	input  logic                       job_ready,
	output logic [INT_BITS-1:0]        job_m,
	output logic [FRAC_BITS-1:0]       job_f,
	output rca_pkg::rca_job_ctl_t      job_ctl
);

	logic [63:0]                 int_wide;
	logic [63:0]                 frac_wide;
	logic [INT_BITS-1:0]         m_in;
	logic [FRAC_BITS-1:0]        f_in;
	logic [4:0]                  radix_eff;
	rca_pkg::rca_job_ctl_t       ctl_in;

	logic [INT_BITS-1:0]         m_q   [2];
	logic [FRAC_BITS-1:0]        f_q   [2];
	rca_pkg::rca_job_ctl_t       ctl_q [2];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic                        push;
	logic                        pop;

	assign int_wide  = 64'(item_data.int_part);
	assign frac_wide = 64'(item_data.frac_part);
	assign m_in      = int_wide[INT_BITS-1:0];
	assign f_in      = frac_wide[FRAC_BITS-1:0];

	// out-of-range radix saturates
	always_comb begin
		if (radix < rca_pkg::RADIX_MIN) begin
			radix_eff = rca_pkg::RADIX_MIN;
		end else if (radix > rca_pkg::RADIX_MAX) begin
			radix_eff = rca_pkg::RADIX_MAX;
		end else begin
			radix_eff = radix;
		end
	end

	assign ctl_in.radix    = radix_eff;
	assign ctl_in.int_zero = (m_in == '0);

	assign item_ready = (cnt_q != 2'd2);
	assign job_valid  = (cnt_q != 2'd0);
	assign push       = item_valid && item_ready;
	assign pop        = job_valid && job_ready;

	assign job_m   = m_q[rd_ptr_q];
	assign job_f   = f_q[rd_ptr_q];
	assign job_ctl = ctl_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			m_q[wr_ptr_q]   <= m_in;
			f_q[wr_ptr_q]   <= f_in;
			ctl_q[wr_ptr_q] <= ctl_in;
		end
	end

endmodule

@@ src/rca_back.sv @@
// rca_back: conversion engine. Integer digits via an 8-bit-per-cycle divider
// into a digit memory, then characters out MSB first, '.', fraction digits.
// Depends on rca_pkg.

module rca_back #(
	parameter int INT_BITS       = 32,
	parameter int FRAC_BITS      = 32,
	parameter int FRAC_DIGITS    = 10,
	parameter int MAX_INT_DIGITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	output logic                       job_ready,
	input  logic [INT_BITS-1:0]        job_m,
	input  logic [FRAC_BITS-1:0]       job_f,
	input  rca_pkg::rca_job_ctl_t      job_ctl,
	output logic                       char_valid,
	input  logic                       char_ready,
	output rca_pkg::rca_out_t          char_data
);

	localparam int DIV_STEPS = (INT_BITS + 7) / 8;
	localparam int DIV_W     = DIV_STEPS * 8;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int ADDR_W    = $clog2(MAX_INT_DIGITS);
	localparam int FD_W      = $clog2(FRAC_DIGITS + 1);
	localparam int PROD_W    = FRAC_BITS + 5;

	localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(MAX_INT_DIGITS - 1);
	localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(DIV_STEPS - 1);
	localparam logic [FD_W-1:0]   FD_LAST   = FD_W'(FRAC_DIGITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_INT,
		ST_DOT,
		ST_FRAC
	} state_t;

	state_t                 state_q;
	logic [DIV_W-1:0]       dv_q;
	logic [3:0]             rem_q;
	logic [4:0]             r_q;
	logic [FRAC_BITS-1:0]   f_q;
	logic [STEP_W-1:0]      step_q;
	logic [ADDR_W-1:0]      n_q;
	logic [FD_W-1:0]        fcnt_q;
	logic                   char_valid_q;
	rca_pkg::rca_out_t      char_data_q;

	logic [DIV_W-1:0]       dv_nx;
	logic [3:0]             rem_nx;
	logic [PROD_W-1:0]      prod;
	logic                   slot_free;
	logic                   emit_char;

	logic [3:0]             dig_mem [MAX_INT_DIGITS];
	logic [3:0]             rd_q;
	logic [ADDR_W-1:0]      rd_addr;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_wa;
	logic [3:0]             mem_wd;

	assign job_ready  = (state_q == ST_IDLE);
	assign slot_free  = !char_valid_q || char_ready;
	assign emit_char  = slot_free && (state_q inside {ST_INT, ST_DOT, ST_FRAC});
	assign char_valid = char_valid_q;
	assign char_data  = char_data_q;

	// eight restoring division steps on a narrow remainder
	always_comb begin
		logic [4:0] rem;
		logic [7:0] top;
		logic [7:0] qb;
		rem = {1'b0, rem_q};
		top = dv_q[DIV_W-1 -: 8];
		qb  = '0;
		for (int i = 7; i >= 0; i--) begin
			rem = {rem[3:0], top[i]};
			if (rem >= r_q) begin
				rem   = rem - r_q;
				qb[i] = 1'b1;
			end
		end
		rem_nx = rem[3:0];
		dv_nx  = (dv_q << 8) | DIV_W'(qb);
	end

	// fraction step: digit sits above the binary point
	assign prod = PROD_W'(f_q) * PROD_W'(r_q);

	// digit memory ports
	assign mem_we = (state_q == ST_DIV && step_q == '0)
		|| (state_q == ST_IDLE && job_valid && job_ctl.int_zero);
	assign mem_wa = (state_q == ST_IDLE) ? '0 : n_q;
	assign mem_wd = (state_q == ST_IDLE) ? 4'd0 : rem_nx;
	// read ahead at the index the next cycle will emit
	assign rd_addr = (state_q == ST_INT && slot_free && n_q != '0)
		? n_q - ADDR_W'(1) : n_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dig_mem[mem_wa] <= mem_wd;
		end
		rd_q <= dig_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			char_valid_q <= 1'b0;
			n_q          <= '0;
			step_q       <= '0;
			fcnt_q       <= '0;
		end else begin
			if (emit_char) begin
				char_valid_q <= 1'b1;
			end else if (char_ready) begin
				char_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						dv_q    <= DIV_W'(job_m);
						f_q     <= job_f;
						r_q     <= job_ctl.radix;
						rem_q   <= 4'd0;
						step_q  <= STEP_INIT;
						n_q     <= '0;
						state_q <= job_ctl.int_zero ? ST_PREP : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q != '0) begin
						dv_q   <= dv_nx;
						rem_q  <= rem_nx;
						step_q <= step_q - STEP_W'(1);
					end else if (dv_nx != '0 && n_q != LAST_IDX) begin
						dv_q   <= dv_nx;
						rem_q  <= 4'd0;
						step_q <= STEP_INIT;
						n_q    <= n_q + ADDR_W'(1);
					end else begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_INT;
				end
				ST_INT: begin
					if (slot_free) begin
						char_data_q.ascii_char <= rca_pkg::digit_char(rd_q);
						char_data_q.last       <= 1'b0;
						if (n_q == '0) begin
							state_q <= ST_DOT;
						end else begin
							n_q <= n_q - ADDR_W'(1);
						end
					end
				end
				ST_DOT: begin
					if (slot_free) begin
						char_data_q.ascii_char <= rca_pkg::DOT_CHAR;
						char_data_q.last       <= 1'b0;
						fcnt_q                 <= '0;
						state_q                <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					if (slot_free) begin
						char_data_q.ascii_char <= rca_pkg::digit_char(prod[FRAC_BITS +: 4]);
						char_data_q.last       <= (fcnt_q == FD_LAST);
						f_q                    <= prod[FRAC_BITS-1:0];
						if (fcnt_q == FD_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							fcnt_q <= fcnt_q + FD_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/radix_conversion_to_ascii.sv @@
// radix_conversion_to_ascii: top level of the fixed-point to digit string
// converter. Depends on rca_pkg, rca_front and rca_back.
//
// Each input beat is an unsigned fixed-point value (int_part . frac_part,
// the fraction scaled by 2^FRAC_BITS). The block answers with a string of
// ascii beats in the radix held in the config register (2..16, reset 10,
// values outside saturate): the integer digits most significant first, a
// single '0' for a zero integer part, then '.', then exactly FRAC_DIGITS
// fraction digits, truncated; last marks the final fraction digit. Letters
// above nine are uppercase. An input beat is taken into a two-entry job
// queue, so up to two numbers can wait while one is converted and while a
// finished character waits in the output register. The conversion engine
// takes one number at a time; the divider that peels off the integer digits,
// eight dividend bits per cycle, finishes every integer digit before the
// string begins. A zero integer part skips the divider.
// The radix register may be written only while the block is idle.

module radix_conversion_to_ascii #(
	parameter int INT_BITS       = 32,
	parameter int FRAC_BITS      = 32,
	parameter int FRAC_DIGITS    = 10,
	parameter int MAX_INT_DIGITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// config
	input  logic                cfg_we,
	input  logic [4:0]          cfg_wdata,
	// number in
	input  logic                item_valid,
	output logic                item_ready,
	input  rca_pkg::rca_in_t    item_data,
	// characters out
	output logic                char_valid,
	input  logic                char_ready,
	output rca_pkg::rca_out_t   char_data
);

	logic [4:0]                 radix_q;

	// front to back job handoff
	logic                       job_valid;
	logic                       job_ready;
	logic [INT_BITS-1:0]        job_m;
	logic [FRAC_BITS-1:0]       job_f;
	rca_pkg::rca_job_ctl_t      job_ctl;

	// radix register, raw value; saturation happens per job in the front end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rca_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// accept, mask, classify and queue
	rca_front #(
		.INT_BITS  (INT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix      (radix_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_data  (item_data),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job_m      (job_m),
		.job_f      (job_f),
		.job_ctl    (job_ctl)
	);

	// divide, buffer digits, emit string
	rca_back #(
		.INT_BITS       (INT_BITS),
		.FRAC_BITS      (FRAC_BITS),
		.FRAC_DIGITS    (FRAC_DIGITS),
		.MAX_INT_DIGITS (MAX_INT_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job_m      (job_m),
		.job_f      (job_f),
		.job_ctl    (job_ctl),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data)
	);

endmodule

@@ src/rca_chk.sv @@
// rca_chk: port-level checks on the character stream of the converter,
// bound to the top level. Depends on rca_pkg and radix_conversion_to_ascii.

module rca_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              char_valid,
	input logic              char_ready,
	input rca_pkg::rca_out_t char_data
);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(char_data))
		else $error("char beat changed while stalled");

	// only digits, uppercase hex letters or the separator
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (char_data.ascii_char == rca_pkg::DOT_CHAR)
			|| (char_data.ascii_char >= 7'h30 && char_data.ascii_char <= 7'h39)
			|| (char_data.ascii_char >= 7'h41 && char_data.ascii_char <= 7'h46))
		else $error("illegal character");

	// the separator never ends a number
	a_dot_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_data.ascii_char == rca_pkg::DOT_CHAR |-> !char_data.last)
		else $error("separator flagged last");

	// an accepted separator is not directly followed by a second one
	a_dot_once: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready && char_data.ascii_char == rca_pkg::DOT_CHAR
		|=> !(char_valid && char_data.ascii_char == rca_pkg::DOT_CHAR))
		else $error("two separators in a row");

endmodule

bind radix_conversion_to_ascii rca_chk u_chk (.*);

@@ test/rca_checker.sv @@
// rca_checker: watches both beat channels of radix_conversion_to_ascii, keeps its own
// copy of the radix register, predicts every character string and compares it.
// Depends on rca_pkg for the beat types and the radix reset value.
`timescale 1ns / 100ps

module rca_checker #(
	parameter int FRAC_DIGITS    = 10,
	parameter int MAX_INT_DIGITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [4:0]          cfg_wdata,
	input  logic                item_valid,
	input  logic                item_ready,
	input  rca_pkg::rca_in_t    item_data,
	input  logic                char_valid,
	input  logic                char_ready,
	input  rca_pkg::rca_out_t   char_data,
	output int                  fail_count,
	output int                  chars_due
);

	localparam logic [6:0] CH_ZERO       = 7'h30;
	localparam logic [6:0] CH_LETTER_OFS = 7'h37;	// 'A' minus ten
	localparam logic [6:0] CH_POINT      = 7'h2E;

	logic [4:0]          radix_shadow;
	rca_pkg::rca_out_t   due_chars[$];

	function automatic logic [6:0] glyph(input logic [3:0] d);
		return (d > 4'd9) ? CH_LETTER_OFS + 7'(d) : CH_ZERO + 7'(d);
	endfunction

	// integer digits by repeated division, then point, then fraction digits
	// by repeated multiplication, truncated
	task automatic queue_digit_string(input rca_pkg::rca_in_t num);
		logic [4:0]  base;
		logic [31:0] whole;
		logic [31:0] frac;
		logic [63:0] prod;
		logic [3:0]  int_digits[MAX_INT_DIGITS];
		int          n;
		int          i;
		base = radix_shadow;
		if (base < 5'd2) begin
			base = 5'd2;
		end else if (base > 5'd16) begin
			base = 5'd16;
		end
		whole = num.int_part;
		frac  = num.frac_part;
		n     = 0;
		do begin
			int_digits[n] = 4'(whole % base);
			whole = whole / base;
			n++;
		end while (whole != 0 && n < MAX_INT_DIGITS);
		for (i = n - 1; i >= 0; i--) begin
			due_chars.push_back({glyph(int_digits[i]), 1'b0});
		end
		due_chars.push_back({CH_POINT, 1'b0});
		for (i = 0; i < FRAC_DIGITS; i++) begin
			prod = 64'(frac) * 64'(base);
			frac = prod[31:0];
			due_chars.push_back({glyph(prod[35:32]), i == FRAC_DIGITS - 1});
		end
	endtask

	always @(posedge clk) begin : watch
		rca_pkg::rca_out_t want;
		if (!arst_n) begin
			radix_shadow = rca_pkg::RADIX_RESET;
			due_chars.delete();
		end else begin
			if (cfg_we) begin
				radix_shadow = cfg_wdata;
			end
			if (char_valid && char_ready) begin
				if (due_chars.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("[%0t] unexpected char beat '%c' last=%0b", $time,
							char_data.ascii_char, char_data.last);
					end
				end else begin
					want = due_chars.pop_front();
					if (char_data.ascii_char !== want.ascii_char ||
							char_data.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display({"[%0t] char mismatch: expected '%c' last=%0b, ",
								"got '%c' (%h) last=%0b"},
								$time, want.ascii_char, want.last, char_data.ascii_char,
								char_data.ascii_char, char_data.last);
						end
					end
				end
			end
			if (item_valid && item_ready) begin
				queue_digit_string(item_data);
			end
		end
		chars_due = due_chars.size();
	end

endmodule

@@ test/tb_radix_conversion_to_ascii.sv @@
// tb_radix_conversion_to_ascii: stimulus and verdict for radix_conversion_to_ascii.
// Depends on rca_pkg, the block itself and rca_checker, which does all the checking.
`timescale 1ns / 100ps

module tb_radix_conversion_to_ascii;

	localparam int FRAC_DIGITS      = 10;
	localparam int MAX_INT_DIGITS   = 32;
	localparam int RANDOM_PER_PHASE = 33;
	// radix 2 on a full integer part gives the longest wait before the first
	// character, and this limit is many times that quiet stretch
	localparam int STALL_LIMIT      = 5000;
	localparam int DRAIN_CYCLES     = 250;
	// register values per phase: both ends, the saturating values below 2 and
	// above 16, and a few ordinary bases; the last phase picks one at random
	localparam logic [4:0] RADIX_PLAN [11] = '{
		5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd3, 5'd8, 5'd12, 5'd7, 5'd10
	};

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [4:0]          cfg_wdata  = 5'd0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	rca_pkg::rca_in_t    item_data  = '0;
	logic                char_valid;
	logic                char_ready = 1'b0;
	rca_pkg::rca_out_t   char_data;

	int fail_count;
	int chars_due;
	bit send_gaps   = 1'b0;
	bit recv_gaps   = 1'b0;
	int recv_hold   = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	radix_conversion_to_ascii #(
		.INT_BITS       (32),
		.FRAC_BITS      (32),
		.FRAC_DIGITS    (FRAC_DIGITS),
		.MAX_INT_DIGITS (MAX_INT_DIGITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_data  (item_data),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data)
	);

	rca_checker #(
		.FRAC_DIGITS    (FRAC_DIGITS),
		.MAX_INT_DIGITS (MAX_INT_DIGITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_data  (item_data),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.fail_count (fail_count),
		.chars_due  (chars_due)
	);

	// character sink: drops ready in random bursts while gaps are on
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold  <= recv_hold - 1;
			char_ready <= 1'b0;
		end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
			recv_hold  <= $urandom_range(0, 3);
			char_ready <= 1'b0;
		end else begin
			char_ready <= 1'b1;
		end
	end

	// watchdog: too long without any beat on either channel ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (char_valid && char_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d chars still due",
					STALL_LIMIT, chars_due);
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one number beat; called and returns at a falling edge, valid stays up
	// for a back-to-back beat unless a gap is drawn
	task automatic send_number(input logic [31:0] ip, input logic [31:0] fp);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_data  <= {ip, fp};
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	// the register may only change while the block is idle, so hold the
	// sender until every character already owed has come out
	task automatic write_radix(input logic [4:0] value);
		item_valid <= 1'b0;
		while (chars_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// integer parts of every size so all digit counts show up
	function automatic logic [31:0] pick_int();
		int w;
		w = $urandom_range(1, 32);
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom & (32'hFFFF_FFFF >> (32 - w));
		endcase
	endfunction

	// fractions: zero, all ones, single bits, short exact ones and full random
	function automatic logic [31:0] pick_frac();
		int w;
		w = $urandom_range(1, 32);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return $urandom & ~(32'hFFFF_FFFF >> w);
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		int p;
		int k;
		logic [4:0] r;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset radix of ten: zero integer part, extremes, alternating bits
		send_gaps <= 1'b1;
		recv_gaps <= 1'b1;
		send_number(32'd0, 32'd0);
		send_number(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_number(32'd1, 32'h8000_0000);
		send_number(32'd10, 32'd1);
		send_number(32'd0, 32'hFFFF_FFFF);
		send_number(32'h5555_5555, 32'hAAAA_AAAA);
		send_number(32'hAAAA_AAAA, 32'h5555_5555);
		for (k = 0; k < RANDOM_PER_PHASE; k++) begin
			send_number(pick_int(), pick_frac());
		end

		for (p = 0; p < 11; p++) begin
			r = (p == 10) ? 5'($urandom_range(0, 31)) : RADIX_PLAN[p];
			write_radix(r);
			// the final phase runs without gaps on either side
			send_gaps <= (p != 10) && ($urandom_range(0, 3) != 0);
			recv_gaps <= (p != 10) && ($urandom_range(0, 3) != 0);
			// one extreme per phase: the longest string, or zero with a full fraction
			if (p % 2 == 0) begin
				send_number(32'hFFFF_FFFF, 32'hFFFF_FFFF);
			end else begin
				send_number(32'd0, 32'hFFFF_FFFF);
			end
			for (k = 0; k < RANDOM_PER_PHASE; k++) begin
				send_number(pick_int(), pick_frac());
			end
		end

		item_valid <= 1'b0;
		while (chars_due != 0) @(negedge clk);
		// let any stray beat surface before the verdict
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
